// ----- rtl/slip_packet_framer_assert.svh -----
// Assertion macros shared by the verification side of the framer.
`ifndef SLIP_PACKET_FRAMER_ASSERT_SVH
`define SLIP_PACKET_FRAMER_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define SLIPFR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define SLIPFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define SLIPFR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/slipfr_pkg.sv -----
`default_nettype none

package slipfr_pkg;

   localparam logic [7:0] FrameEnd    = 8'hC0;
   localparam logic [7:0] FrameEsc    = 8'hDB;
   localparam logic [7:0] FrameEscEnd = 8'hDC;
   localparam logic [7:0] FrameEscEsc = 8'hDD;

   // Depth of the job queue between the classifier and the encoder.
   localparam int QueueDepth = 2;

   // One classified packet byte, as handed from the front to the back.
   typedef struct packed {
      logic [7:0] data;     // raw packet byte
      logic       escape;   // byte is END or ESC and goes out as two bytes
      logic       lead;     // an opening END goes out before the byte
      logic       close;    // a closing END goes out after the byte
   } job_type;

endpackage

`default_nettype wire

// ----- rtl/slipfr_front.sv -----
`default_nettype none

module slipfr_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire  [7:0]           req_tdata,
   output logic                 push_valid,
   input  wire                  push_ready,
   output slipfr_pkg::job_type  push_job
);

   typedef enum logic [4:0] {
      POS_HEADER = 5'b00001,
      POS_X      = 5'b00010,
      POS_Y      = 5'b00100,
      POS_LENGTH = 5'b01000,
      POS_DATA   = 5'b10000
   } field_pos_type;

   field_pos_type position_ff, position_in;
   logic [7:0]    remaining_ff, remaining_in;
   logic          accept;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid && push_ready;

   always_comb begin
      position_in     = position_ff;
      remaining_in    = remaining_ff;
      push_job.data   = req_tdata;
      push_job.escape = (req_tdata == slipfr_pkg::FrameEnd) ||
                        (req_tdata == slipfr_pkg::FrameEsc);
      push_job.lead   = 1'b0;
      push_job.close  = 1'b0;
      case (position_ff)
         POS_X: begin
            position_in = POS_Y;
         end
         POS_Y: begin
            position_in = POS_LENGTH;
         end
         POS_LENGTH: begin
            remaining_in = req_tdata;
            if (req_tdata == 8'd0) begin
               push_job.close = 1'b1;
               position_in    = POS_HEADER;
            end else begin
               position_in = POS_DATA;
            end
         end
         POS_DATA: begin
            if (remaining_ff <= 8'd1) begin
               push_job.close = 1'b1;
               remaining_in   = 8'd0;
               position_in    = POS_HEADER;
            end else begin
               remaining_in = remaining_ff - 8'd1;
            end
         end
         default: begin
            push_job.lead = 1'b1;
            position_in   = POS_X;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= POS_HEADER;
         remaining_ff <= 8'd0;
      end else if (accept) begin
         position_ff  <= position_in;
         remaining_ff <= remaining_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/slipfr_queue.sv -----
`default_nettype none

module slipfr_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push_valid,
   output logic                 push_ready,
   input  slipfr_pkg::job_type  push_job,
   output logic                 pop_valid,
   input  wire                  pop,
   output slipfr_pkg::job_type  pop_job
);

   localparam int PtrWidth   = (slipfr_pkg::QueueDepth > 1) ?
                               $clog2(slipfr_pkg::QueueDepth) : 1;
   localparam int CountWidth = $clog2(slipfr_pkg::QueueDepth + 1);
   localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(slipfr_pkg::QueueDepth - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(slipfr_pkg::QueueDepth);

   slipfr_pkg::job_type entries_ff [slipfr_pkg::QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != FullCount);
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/slipfr_back.sv -----
`default_nettype none

module slipfr_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  job_valid,
   input  slipfr_pkg::job_type  job,
   output logic                 job_pop,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tlast,
   output logic                 rsp_tuser
);

   logic [1:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       last_ff;
   logic       done_ff;

   logic [7:0] seq [3];
   logic [1:0] last_step;
   logic [7:0] esc_second;
   logic       load;
   logic       emit;
   logic       is_last;

   assign esc_second = (job.data == slipfr_pkg::FrameEnd) ?
                       slipfr_pkg::FrameEscEnd : slipfr_pkg::FrameEscEsc;

   // Byte sequence of the head job; an opening and a closing END never meet.
   always_comb begin
      seq[0]    = job.data;
      seq[1]    = slipfr_pkg::FrameEnd;
      seq[2]    = slipfr_pkg::FrameEnd;
      last_step = 2'd0;
      if (job.lead && job.escape) begin
         seq[0]    = slipfr_pkg::FrameEnd;
         seq[1]    = slipfr_pkg::FrameEsc;
         seq[2]    = esc_second;
         last_step = 2'd2;
      end else if (job.lead) begin
         seq[0]    = slipfr_pkg::FrameEnd;
         seq[1]    = job.data;
         last_step = 2'd1;
      end else if (job.escape) begin
         seq[0]    = slipfr_pkg::FrameEsc;
         seq[1]    = esc_second;
         last_step = job.close ? 2'd2 : 2'd1;
      end else if (job.close) begin
         last_step = 2'd1;
      end
   end

   assign load    = !valid_ff || rsp_tready;
   assign emit    = job_valid && load;
   assign is_last = (step_ff == last_step);
   assign job_pop = emit && is_last;

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff && !rsp_tready;
      if (emit) begin
         valid_in = 1'b1;
         step_in  = is_last ? 2'd0 : step_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         data_ff <= (step_ff == 2'd2) ? seq[2] : ((step_ff == 2'd1) ? seq[1] : seq[0]);
         last_ff <= is_last;
         done_ff <= is_last && job.close;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = done_ff;

endmodule

`default_nettype wire

// ----- rtl/slip_packet_framer.sv -----
// Channel    | Dir | Ports            | Contents
// -----------+-----+------------------+--------------------------------------------
// request    | in  | req_t*           | tdata[7:0] in_byte
// response   | out | rsp_t*           | tdata[7:0] out_byte, tlast run_last,
//            |     |                  | tuser[0] frame_done
//
// Every request turns into one, two or three response bytes. The encoder sends one
// byte per cycle on the single response port while it is not stalled; the first byte
// passes through the job queue and then the output register before it is valid.
// Reset is synchronous and active high; it returns the framer to expecting a header
// and empties the job queue and the output register.
// The request side stalls only when the two-entry job queue is full; the response
// register can reload whenever it is empty or its byte is taken in the same cycle.
`default_nettype none

module slip_packet_framer (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,    // [7:0] in_byte
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_byte
   output logic       rsp_tlast,
   output logic       rsp_tuser     // [0] frame_done
);

   // Jobs leave the classifier already tagged with the opening END, the escape and
   // the closing END, so the encoder never needs the packet position.
   logic                push_valid;
   logic                push_ready;
   slipfr_pkg::job_type push_job;
   logic                pop_valid;
   logic                pop;
   slipfr_pkg::job_type pop_job;

   slipfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   slipfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_job    (pop_job)
   );

   // The encoder walks the head job one output byte per cycle unless the response port
   // stalls, and pops it with the last byte, which also carries tlast.
   slipfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (pop_valid),
      .job        (pop_job),
      .job_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ----- rtl/slipfr_monitor.sv -----
`default_nettype none
`include "slip_packet_framer_assert.svh"

module slipfr_monitor (
   input wire       clock,
   input wire       reset,
   input wire       req_tvalid,
   input wire       req_tready,
   input wire [7:0] req_tdata,
   input wire       rsp_tvalid,
   input wire       rsp_tready,
   input wire [7:0] rsp_tdata,
   input wire       rsp_tlast,
   input wire       rsp_tuser
);

   logic        rsp_stall;
   logic        req_stall;
   logic        done;
   logic        is_end;
   logic [10:0] rsp_word;
   logic [8:0]  req_word;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign req_stall = req_tvalid && !req_tready;
   assign done      = rsp_tvalid && rsp_tuser;
   assign is_end    = (rsp_tdata == slipfr_pkg::FrameEnd);
   assign rsp_word  = {rsp_tvalid, rsp_tdata, rsp_tlast, rsp_tuser};
   assign req_word  = {req_tvalid, req_tdata};

   // The closing END is always the final byte of its request.
   `SLIPFR_ASSERT_NOW(a_done_is_last, clock, reset, done, rsp_tlast, "close without tlast")
   // A frame is closed only by a raw END byte.
   `SLIPFR_ASSERT_NOW(a_done_is_end, clock, reset, done, is_end, "close not on END")
   // A stalled response keeps its valid, byte and flags.
   `SLIPFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, $stable(rsp_word), "response moved")
   // A waiting request keeps its valid and byte until it is taken.
   `SLIPFR_ASSERT_NEXT(a_req_hold, clock, reset, req_stall, $stable(req_word), "request moved")
   // Reset empties the output register.
   `SLIPFR_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "valid after reset")

endmodule

bind slip_packet_framer slipfr_monitor u_monitor (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
